// ----- src/esctcg_pkg.sv -----
// ----------------------------------------------------------------------------
// esctcg_pkg: shared constants for the esc throttle command generator
// throttle modes, request codes, register indexes and servo timing constants
// ----------------------------------------------------------------------------
package esctcg_pkg;

  // default servo pulse width in bits
  localparam int PULSE_BITS_DEF = 12;

  // configuration port
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_THROTTLE_MODE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PWM_ON_DUTY    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PWM_COAST_DUTY = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PWM_OFF_DUTY   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DYN_FULL_SCALE = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_TRANSLATE_GAIN = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_COAST_FRACTION = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_DIRECT_CONTROL = 3'd7;

  // throttle modes
  localparam logic [1:0] MODE_BINARY    = 2'd0;
  localparam logic [1:0] MODE_PWM_FIXED = 2'd1;
  localparam logic [1:0] MODE_PWM_DYN   = 2'd2;
  localparam logic [1:0] MODE_SERVO     = 2'd3;

  // request types
  localparam logic [1:0] REQ_ON    = 2'd0;
  localparam logic [1:0] REQ_COAST = 2'd1;
  localparam logic [1:0] REQ_OFF   = 2'd2;
  localparam logic [1:0] REQ_LOAD  = 2'd3;

  // servo timing and fixed-point constants
  localparam int NEUTRAL_US      = 1500;
  localparam int SPAN_US         = 500;
  localparam int FULL_US         = NEUTRAL_US + SPAN_US;
  localparam int ONE_Q14         = 16384;

  // register reset values
  localparam logic [1:0]  RST_MODE       = MODE_SERVO;
  localparam logic [7:0]  RST_ON_DUTY    = 8'd255;
  localparam logic [15:0] RST_FULL_SCALE = 16'hFFFF;
  localparam logic [15:0] RST_GAIN       = 16'd16384;

endpackage

// ----- src/esc_throttle_command_generator.sv -----
// ----------------------------------------------------------------------------
// esc_throttle_command_generator: motor command to drive value
// maps on, coast, off and load commands for two motors to a pin level, a pwm
// duty or an rc servo pulse width, using a bit-serial multiplier and divider
// ----------------------------------------------------------------------------
//
// usage
//   input channel (in_*): one command word per motor phase; accepted when
//   in_valid is high and in_stall is low. in_stall is high while a word is
//   being worked on, so one word is in flight at a time.
//   result channel (out_*): exactly one result word per command, held in an
//   output register; a word taken when out_valid is high and out_stall low.
//   configuration (cfg_*): write-only, one register per cycle; the user writes
//   only while idle, which the block itself does not enforce.
// steps, accept to out_valid, by the shift-add multiplier (one multiplier bit
//   per cycle) and restoring divider (one quotient bit), then the final step:
//     load, binary, fixed pwm, pwm coast/off, servo off and neutral cases: none
//     servo on: 16 multiplier bits
//     dynamic pwm on: 16 multiply + 24 divide
//     servo coast: 16 bits for the blend, 31 bits for the scaling
//   the next word is accepted the cycle after the previous result is loaded.
// reset: registers return to their defaults (servo mode), both stored pulses
//   to neutral, no result pending.
// stall: a finished result waits in the output register; a second finished
//   result waits in the final step until the register frees up.
// ----------------------------------------------------------------------------
module esc_throttle_command_generator
  import esctcg_pkg::*;
#(
  parameter int PULSE_BITS = PULSE_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,

  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [1:0]            in_req_type,
  input  logic                  in_motor_sel,
  input  logic [15:0]           in_throttle,
  input  logic                  in_translating,
  input  logic [15:0]           in_translation_scale,
  input  logic [11:0]           in_load_width,

  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  out_motor_id,
  output logic                  out_pin_level,
  output logic [7:0]            out_pwm_duty,
  output logic [PULSE_BITS-1:0] out_pulse_us,

  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_W-1:0]      cfg_wdata
);

  // accumulator holds range * blend (PULSE_BITS+1 by 31 bits, signed)
  localparam int ACC_W  = PULSE_BITS + 32;
  localparam int V_W    = PULSE_BITS + 4;   // signed pulse before saturation
  localparam int MPLR_W = 31;
  localparam int DIVQ_W = 24;
  localparam int CNT_W  = 5;
  localparam int RNG_W  = PULSE_BITS + 1;

  localparam logic [CNT_W-1:0] STEPS_MUL  = CNT_W'(15);
  localparam logic [CNT_W-1:0] STEPS_MUL2 = CNT_W'(MPLR_W - 1);
  localparam logic [CNT_W-1:0] STEPS_DIV  = CNT_W'(DIVQ_W - 1);

  localparam logic [MPLR_W-1:0]       Q30_ONE     = MPLR_W'(32'h4000_0000);
  localparam logic signed [V_W-1:0]   PULSE_MAX_V = V_W'((1 << PULSE_BITS) - 1);
  localparam logic signed [V_W-1:0]   NEUTRAL_V   = V_W'(NEUTRAL_US);
  localparam logic signed [V_W-1:0]   FULL_V      = V_W'(FULL_US);

  // sequencer states
  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MUL  = 3'd1;
  localparam logic [2:0] ST_MUL2 = 3'd2;
  localparam logic [2:0] ST_DIV  = 3'd3;
  localparam logic [2:0] ST_FIN  = 3'd4;

  // what the sequencer computes for the held word
  localparam logic [2:0] OP_PLAIN  = 3'd0;
  localparam logic [2:0] OP_DYN    = 3'd1;
  localparam logic [2:0] OP_DIRECT = 3'd2;
  localparam logic [2:0] OP_TRANS  = 3'd3;
  localparam logic [2:0] OP_COAST  = 3'd4;

  // ---------------------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------------------
  logic [1:0]         mode_r;
  logic [7:0]         on_duty_r;
  logic [7:0]         coast_duty_r;
  logic [7:0]         off_duty_r;
  logic [15:0]        full_scale_r;
  logic [15:0]        gain_r;
  logic signed [15:0] coast_frac_r;
  logic               direct_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r       <= RST_MODE;
      on_duty_r    <= RST_ON_DUTY;
      coast_duty_r <= '0;
      off_duty_r   <= '0;
      full_scale_r <= RST_FULL_SCALE;
      gain_r       <= RST_GAIN;
      coast_frac_r <= '0;
      direct_r     <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_THROTTLE_MODE:  mode_r       <= cfg_wdata[1:0];
        CFG_PWM_ON_DUTY:    on_duty_r    <= cfg_wdata[7:0];
        CFG_PWM_COAST_DUTY: coast_duty_r <= cfg_wdata[7:0];
        CFG_PWM_OFF_DUTY:   off_duty_r   <= cfg_wdata[7:0];
        CFG_DYN_FULL_SCALE: full_scale_r <= cfg_wdata;
        CFG_TRANSLATE_GAIN: gain_r       <= cfg_wdata;
        CFG_COAST_FRACTION: coast_frac_r <= $signed(cfg_wdata);
        CFG_DIRECT_CONTROL: direct_r     <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // zero full scale acts as one
  logic [15:0] fs_eff;
  assign fs_eff = (full_scale_r == '0) ? 16'd1 : full_scale_r;

  // ---------------------------------------------------------------------------
  // sequencer and datapath registers
  // ---------------------------------------------------------------------------
  logic [2:0]              state_r, state_nxt;
  logic [2:0]              op_r, op_nxt;
  logic [CNT_W-1:0]        cnt_r, cnt_nxt;
  logic signed [ACC_W-1:0] acc_r, acc_nxt;
  logic signed [ACC_W-1:0] mcand_r, mcand_nxt;
  logic [MPLR_W-1:0]       mplr_r, mplr_nxt;
  logic [DIVQ_W-1:0]       divq_r, divq_nxt;
  logic [15:0]             rem_r, rem_nxt;
  logic                    neg_r, neg_nxt;
  logic [1:0]              req_r, req_nxt;
  logic                    motor_r, motor_nxt;
  logic [11:0]             load_r, load_nxt;

  logic                    out_valid_r, out_valid_nxt;
  logic                    out_motor_r, out_motor_nxt;
  logic                    out_pin_r, out_pin_nxt;
  logic [7:0]              out_duty_r, out_duty_nxt;
  logic [PULSE_BITS-1:0]   out_pulse_r, out_pulse_nxt;

  logic [PULSE_BITS-1:0]   pulse_store_r [2];

  // ---------------------------------------------------------------------------
  // decode of a new command word and multiplier operands
  // ---------------------------------------------------------------------------
  logic signed [8:0]       duty_diff;
  logic signed [16:0]      gain_off;
  logic signed [25:0]      gain_mc;
  logic signed [16:0]      coast_off;
  logic [2:0]              op_dec;
  logic [MPLR_W-1:0]       mplr_ld;
  logic signed [ACC_W-1:0] mcand_ld;

  assign duty_diff = $signed({1'b0, on_duty_r}) - $signed({1'b0, coast_duty_r});
  assign gain_off  = $signed({1'b0, gain_r}) - $signed(17'(ONE_Q14));
  // 500 * (gain - 1.0), so that one serial pass gives the whole product
  assign gain_mc   = 26'(gain_off) * $signed(26'(SPAN_US));
  assign coast_off = 17'(coast_frac_r) - $signed(17'(ONE_Q14));

  always_comb begin
    op_dec   = OP_PLAIN;
    mplr_ld  = MPLR_W'(in_throttle);
    mcand_ld = '0;
    if (in_req_type != REQ_LOAD) begin
      if (mode_r == MODE_PWM_DYN && in_req_type == REQ_ON) begin
        op_dec   = OP_DYN;
        mcand_ld = ACC_W'(duty_diff);
      end else if (mode_r == MODE_SERVO) begin
        if (in_req_type == REQ_ON && in_throttle != '0) begin
          if (direct_r || !in_translating) begin
            op_dec   = OP_DIRECT;
            mcand_ld = ACC_W'($signed(11'(SPAN_US)));
          end else begin
            op_dec   = OP_TRANS;
            mplr_ld  = MPLR_W'(in_translation_scale);
            mcand_ld = ACC_W'(gain_mc);
          end
        end else if (in_req_type == REQ_COAST && coast_frac_r > 16'sd0) begin
          op_dec   = OP_COAST;
          mplr_ld  = MPLR_W'(in_translation_scale);
          mcand_ld = ACC_W'(coast_off);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // serial step units
  // ---------------------------------------------------------------------------
  // shift-add multiplier: one multiplier bit per cycle
  logic signed [ACC_W-1:0] mul_sum;
  assign mul_sum = acc_r + (mplr_r[0] ? mcand_r : '0);

  // dividend magnitude and sign for the dynamic duty division
  logic signed [25:0] dyn_prod;
  logic [25:0]        dyn_mag;
  assign dyn_prod = mul_sum[25:0];
  assign dyn_mag  = dyn_prod[25] ? 26'(-dyn_prod) : 26'(dyn_prod);

  // restoring divider: one quotient bit per cycle
  logic [16:0] div_trial;
  logic        div_bit;
  assign div_trial = {rem_r, divq_r[DIVQ_W-1]};
  assign div_bit   = (div_trial >= {1'b0, fs_eff});

  // stored excess above neutral for the held motor
  logic signed [RNG_W-1:0] coast_range;
  assign coast_range = $signed({1'b0, pulse_store_r[motor_r]})
                     - $signed(RNG_W'(NEUTRAL_US));

  // ---------------------------------------------------------------------------
  // result assembly
  // ---------------------------------------------------------------------------
  logic signed [25:0]    dyn_q;
  logic signed [25:0]    dyn_adj;
  logic signed [25:0]    dyn_v;
  logic [7:0]            dyn_duty;
  logic signed [V_W-1:0] acc_q30;
  logic                  fin_pin;
  logic [7:0]            fin_duty;
  logic signed [V_W-1:0] fin_v;
  logic                  fin_we;
  logic [PULSE_BITS-1:0] fin_pulse;

  // floor division: a negative quotient with remainder rounds down
  assign dyn_q   = $signed(26'(divq_r));
  assign dyn_adj = dyn_q + $signed(26'(rem_r != '0));
  assign dyn_v   = $signed(26'(coast_duty_r)) + (neg_r ? -dyn_adj : dyn_q);

  always_comb begin
    if (dyn_v > $signed(26'(on_duty_r))) begin
      dyn_duty = on_duty_r;
    end else if (dyn_v < 26'sd0) begin
      dyn_duty = '0;
    end else begin
      dyn_duty = dyn_v[7:0];
    end
  end

  // floor of the accumulator over 2^30
  assign acc_q30 = V_W'($signed(acc_r[ACC_W-1:30]));

  always_comb begin
    fin_pin  = 1'b0;
    fin_duty = '0;
    fin_v    = '0;
    fin_we   = 1'b0;
    if (req_r == REQ_LOAD) begin
      fin_v  = $signed(V_W'(load_r));
      fin_we = 1'b1;
    end else begin
      case (mode_r)
        MODE_BINARY: fin_pin = (req_r == REQ_ON);
        MODE_PWM_FIXED, MODE_PWM_DYN: begin
          case (req_r)
            REQ_COAST: fin_duty = coast_duty_r;
            REQ_OFF:   fin_duty = off_duty_r;
            default:   fin_duty = (op_r == OP_DYN) ? dyn_duty : on_duty_r;
          endcase
        end
        MODE_SERVO: begin
          fin_we = 1'b1;
          case (op_r)
            OP_DIRECT: fin_v = NEUTRAL_V + $signed(V_W'(acc_r[24:16]));
            OP_TRANS:  fin_v = FULL_V + acc_q30;
            OP_COAST:  fin_v = NEUTRAL_V + acc_q30;
            default:   fin_v = NEUTRAL_V;
          endcase
        end
        default: ;
      endcase
    end
  end

  // saturate to the pulse range
  always_comb begin
    if (fin_v < $signed(V_W'(0))) begin
      fin_pulse = '0;
    end else if (fin_v > PULSE_MAX_V) begin
      fin_pulse = PULSE_MAX_V[PULSE_BITS-1:0];
    end else begin
      fin_pulse = fin_v[PULSE_BITS-1:0];
    end
  end

  // ---------------------------------------------------------------------------
  // sequencer
  // ---------------------------------------------------------------------------
  logic slot_free;
  assign slot_free = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != ST_IDLE);

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    cnt_nxt       = cnt_r;
    acc_nxt       = acc_r;
    mcand_nxt     = mcand_r;
    mplr_nxt      = mplr_r;
    divq_nxt      = divq_r;
    rem_nxt       = rem_r;
    neg_nxt       = neg_r;
    req_nxt       = req_r;
    motor_nxt     = motor_r;
    load_nxt      = load_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_motor_nxt = out_motor_r;
    out_pin_nxt   = out_pin_r;
    out_duty_nxt  = out_duty_r;
    out_pulse_nxt = out_pulse_r;

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          req_nxt   = in_req_type;
          motor_nxt = in_motor_sel;
          load_nxt  = in_load_width;
          op_nxt    = op_dec;
          acc_nxt   = '0;
          mcand_nxt = mcand_ld;
          mplr_nxt  = mplr_ld;
          cnt_nxt   = STEPS_MUL;
          state_nxt = (op_dec == OP_PLAIN) ? ST_FIN : ST_MUL;
        end
      end
      ST_MUL, ST_MUL2: begin
        acc_nxt   = mul_sum;
        mcand_nxt = mcand_r <<< 1;
        mplr_nxt  = mplr_r >> 1;
        cnt_nxt   = cnt_r - CNT_W'(1);
        if (cnt_r == '0) begin
          state_nxt = ST_FIN;
          if (state_r == ST_MUL && op_r == OP_DYN) begin
            // divide |throttle * (on - coast)| by the full scale
            neg_nxt   = dyn_prod[25];
            divq_nxt  = dyn_mag[DIVQ_W-1:0];
            rem_nxt   = '0;
            cnt_nxt   = STEPS_DIV;
            state_nxt = ST_DIV;
          end else if (state_r == ST_MUL && op_r == OP_COAST) begin
            // blend = 2^30 + ts * (coast - 1.0), always positive
            mplr_nxt  = mul_sum[MPLR_W-1:0] + Q30_ONE;
            mcand_nxt = ACC_W'(coast_range);
            acc_nxt   = '0;
            cnt_nxt   = STEPS_MUL2;
            state_nxt = ST_MUL2;
          end
        end
      end
      ST_DIV: begin
        rem_nxt  = div_bit ? 16'(div_trial - {1'b0, fs_eff}) : div_trial[15:0];
        divq_nxt = {divq_r[DIVQ_W-2:0], div_bit};
        cnt_nxt  = cnt_r - CNT_W'(1);
        if (cnt_r == '0) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_motor_nxt = motor_r;
          out_pin_nxt   = fin_pin;
          out_duty_nxt  = fin_duty;
          out_pulse_nxt = fin_pulse;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // stored pulse per motor, neutral after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pulse_store_r[0] <= PULSE_BITS'(NEUTRAL_US);
      pulse_store_r[1] <= PULSE_BITS'(NEUTRAL_US);
    end else if (state_r == ST_FIN && slot_free && fin_we) begin
      pulse_store_r[motor_r] <= fin_pulse;
    end
  end

  // datapath, no reset
  always_ff @(posedge clk) begin
    op_r        <= op_nxt;
    cnt_r       <= cnt_nxt;
    acc_r       <= acc_nxt;
    mcand_r     <= mcand_nxt;
    mplr_r      <= mplr_nxt;
    divq_r      <= divq_nxt;
    rem_r       <= rem_nxt;
    neg_r       <= neg_nxt;
    req_r       <= req_nxt;
    motor_r     <= motor_nxt;
    load_r      <= load_nxt;
    out_motor_r <= out_motor_nxt;
    out_pin_r   <= out_pin_nxt;
    out_duty_r  <= out_duty_nxt;
    out_pulse_r <= out_pulse_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_motor_id  = out_motor_r;
  assign out_pin_level = out_pin_r;
  assign out_pwm_duty  = out_duty_r;
  assign out_pulse_us  = out_pulse_r;

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  // a result only appears from the final step
  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_FIN))
    else $error("result word loaded outside the final step");

  // multiplier passes count down without leaving the pass
  assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_MUL || state_r == ST_MUL2) && cnt_r != '0) |=>
      (state_r == $past(state_r) && cnt_r == CNT_W'($past(cnt_r) - CNT_W'(1))))
    else $error("multiplier step count broken");

  // divider remainder always stays below the divisor
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |-> (rem_r < fs_eff))
    else $error("divider remainder out of range");

  // a finished result waits while the output register is stalled
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FIN && !slot_free) |=> (state_r == ST_FIN))
    else $error("result dropped while output stalled");

endmodule

// ----- tb/esc_throttle_command_generator_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// esc_throttle_command_generator_tb: self-checking bench for the command generator
// feeds motor command words through a valid/stall driver, predicts each result
// word with an independent model of the drive mapping and the stored servo
// pulses, and checks every result word field by field under random stalls
// ----------------------------------------------------------------------------
module esc_throttle_command_generator_tb;
  import esctcg_pkg::*;

  localparam int     PB        = PULSE_BITS_DEF;
  localparam longint PULSE_MAX = (longint'(1) << PB) - 1;
  localparam longint Q30       = longint'(1) << 30;
  localparam int     LONG_HOLD = 400;

  typedef struct {
    logic [1:0]  req;
    logic        motor;
    logic [15:0] thr;
    logic        trans;
    logic [15:0] ts;
    logic [11:0] load;
  } motor_cmd_t;

  typedef struct {
    logic          motor;
    logic          pin;
    logic [7:0]    duty;
    logic [PB-1:0] pulse;
  } drive_word_t;

  // dut ports; the inputs are all known from time zero
  logic                 clk;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [1:0]           in_req_type = REQ_OFF;
  logic                 in_motor_sel = 1'b0;
  logic [15:0]          in_throttle = '0;
  logic                 in_translating = 1'b0;
  logic [15:0]          in_translation_scale = '0;
  logic [11:0]          in_load_width = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic                 out_motor_id;
  logic                 out_pin_level;
  logic [7:0]           out_pwm_duty;
  logic [PB-1:0]        out_pulse_us;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_THROTTLE_MODE;
  logic [CFG_W-1:0]     cfg_wdata = '0;

  // shadow copy of the registers and of the stored servo pulses
  logic [1:0]         mode_r;
  logic [7:0]         on_r, coast_r, off_r;
  logic [15:0]        fs_r, gain_r;
  logic signed [15:0] cf_r;
  logic               direct_r;
  logic [PB-1:0]      pulse_mem [2];

  motor_cmd_t  cmd_pending [$];
  drive_word_t drive_expected [$];
  motor_cmd_t  cur_cmd;

  int  items_sent = 0;
  int  results_seen = 0;
  int  fail_count = 0;
  int  send_gap = 0;
  int  hold_left = 0;
  int  hold_asked = 0;
  int  hold_seen = 0;
  bit  no_gaps = 0;
  bit  took;

  logic [1:0] mode_seq [4] = '{MODE_BINARY, MODE_PWM_FIXED, MODE_PWM_DYN, MODE_SERVO};

  esc_throttle_command_generator #(.PULSE_BITS(PB)) uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_req_type(in_req_type), .in_motor_sel(in_motor_sel),
    .in_throttle(in_throttle), .in_translating(in_translating),
    .in_translation_scale(in_translation_scale), .in_load_width(in_load_width),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_motor_id(out_motor_id), .out_pin_level(out_pin_level),
    .out_pwm_duty(out_pwm_duty), .out_pulse_us(out_pulse_us),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // hard stop well past the slowest legal run
  initial begin
    #2000000;
    $display("TB_ERROR");
    $finish;
  end

  // ---------------------------------------------------------------- prediction

  function automatic longint floor_div(longint n, longint d);
    longint q;
    q = n / d;
    if ((n % d) != 0 && n < 0) q = q - 1;
    return q;
  endfunction

  function automatic logic [PB-1:0] sat_pulse(longint v);
    if (v < 0) return '0;
    if (v > PULSE_MAX) return PULSE_MAX[PB-1:0];
    return v[PB-1:0];
  endfunction

  // expected result word for one command, updates the stored pulse
  function automatic drive_word_t predict_drive(motor_cmd_t c);
    drive_word_t r;
    longint v, on, co, fs, s, excess;
    r.motor = c.motor;
    r.pin   = 1'b0;
    r.duty  = '0;
    r.pulse = '0;
    if (c.req == REQ_LOAD) begin
      r.pulse = sat_pulse(longint'(c.load));
      pulse_mem[c.motor] = r.pulse;
    end else if (mode_r == MODE_BINARY) begin
      r.pin = (c.req == REQ_ON);
    end else if (mode_r == MODE_PWM_FIXED || mode_r == MODE_PWM_DYN) begin
      if (c.req == REQ_COAST) r.duty = coast_r;
      else if (c.req == REQ_OFF) r.duty = off_r;
      else if (mode_r == MODE_PWM_FIXED) r.duty = on_r;
      else begin
        on = longint'(on_r);
        co = longint'(coast_r);
        // zero full scale behaves as one
        fs = (fs_r == 0) ? 1 : longint'(fs_r);
        v  = co + floor_div(longint'(c.thr) * (on - co), fs);
        if (v > on) v = on;
        if (v < 0) v = 0;
        if (v > 255) v = 255;
        r.duty = v[7:0];
      end
    end else begin
      v = NEUTRAL_US;
      if (c.req == REQ_ON && c.thr != 0) begin
        if (direct_r || !c.trans)
          v = NEUTRAL_US + floor_div(longint'(c.thr) * SPAN_US, 65536);
        else
          v = FULL_US + floor_div(longint'(SPAN_US) * (longint'(gain_r) - ONE_Q14) *
                                  longint'(c.ts), Q30);
      end else if (c.req == REQ_COAST && cf_r > 0) begin
        s      = Q30 + longint'(c.ts) * (longint'(cf_r) - ONE_Q14);
        excess = longint'(pulse_mem[c.motor]) - NEUTRAL_US;
        v      = floor_div(longint'(NEUTRAL_US) * Q30 + excess * s, Q30);
      end
      r.pulse = sat_pulse(v);
      pulse_mem[c.motor] = r.pulse;
    end
    return r;
  endfunction

  // ---------------------------------------------------------------- stimulus helpers

  // mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    if (no_gaps) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // edge values or random, masked to w bits
  function automatic logic [15:0] pick_word(int w);
    logic [15:0] m;
    m = 16'((32'd1 << w) - 1);
    case ($urandom_range(0, 5))
      0: return '0;
      1: return m;
      2: return 16'd1;
      default: return 16'($urandom) & m;
    endcase
  endfunction

  function automatic motor_cmd_t mk_cmd(logic [1:0] req, logic m, logic [15:0] thr,
                                        logic tr, logic [15:0] ts, logic [11:0] ld);
    motor_cmd_t c;
    c.req = req; c.motor = m; c.thr = thr; c.trans = tr; c.ts = ts; c.load = ld;
    return c;
  endfunction

  // loads set up the stored pulse so that coasts have something to shrink
  function automatic motor_cmd_t rand_cmd();
    motor_cmd_t c;
    int r;
    r = $urandom_range(0, 9);
    c.req   = (r < 4) ? REQ_ON : (r < 7) ? REQ_COAST : (r < 8) ? REQ_OFF : REQ_LOAD;
    c.motor = 1'($urandom_range(0, 1));
    c.thr   = pick_word(16);
    c.trans = 1'($urandom_range(0, 1));
    c.ts    = pick_word(16);
    if ($urandom_range(0, 3) == 0) c.load = 12'(NEUTRAL_US - 300 + $urandom_range(0, 600));
    else c.load = 12'($urandom);
    return c;
  endfunction

  task automatic send(motor_cmd_t c);
    cmd_pending.push_back(c);
    items_sent++;
  endtask

  task automatic wait_drained();
    while (results_seen < items_sent) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      CFG_THROTTLE_MODE:  mode_r   = val[1:0];
      CFG_PWM_ON_DUTY:    on_r     = val[7:0];
      CFG_PWM_COAST_DUTY: coast_r  = val[7:0];
      CFG_PWM_OFF_DUTY:   off_r    = val[7:0];
      CFG_DYN_FULL_SCALE: fs_r     = val;
      CFG_TRANSLATE_GAIN: gain_r   = val;
      CFG_COAST_FRACTION: cf_r     = val;
      CFG_DIRECT_CONTROL: direct_r = val[0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_config(logic [1:0] mode, logic [7:0] on, logic [7:0] co,
                            logic [7:0] off, logic [15:0] fs, logic [15:0] gain,
                            logic [15:0] cf, logic direct);
    write_reg(CFG_THROTTLE_MODE, 16'(mode));
    write_reg(CFG_PWM_ON_DUTY, 16'(on));
    write_reg(CFG_PWM_COAST_DUTY, 16'(co));
    write_reg(CFG_PWM_OFF_DUTY, 16'(off));
    write_reg(CFG_DYN_FULL_SCALE, fs);
    write_reg(CFG_TRANSLATE_GAIN, gain);
    write_reg(CFG_COAST_FRACTION, cf);
    write_reg(CFG_DIRECT_CONTROL, 16'(direct));
  endtask

  // ---------------------------------------------------------------- driver

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      send_gap = 0;
    end else begin
      took = in_valid && !in_stall;
      if (took) begin
        drive_expected.push_back(predict_drive(cur_cmd));
        send_gap = pick_gap();
      end
      if (!in_valid || took) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (cmd_pending.size() > 0) begin
          cur_cmd = cmd_pending.pop_front();
          in_req_type          <= cur_cmd.req;
          in_motor_sel         <= cur_cmd.motor;
          in_throttle          <= cur_cmd.thr;
          in_translating       <= cur_cmd.trans;
          in_translation_scale <= cur_cmd.ts;
          in_load_width        <= cur_cmd.load;
          in_valid             <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------- monitor

  always @(posedge clk) begin
    drive_word_t exp_w;
    if (!rst_n) begin
      out_stall <= 1'b0;
      hold_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        results_seen++;
        if (drive_expected.size() == 0) begin
          $error("result word with no command pending");
          fail_count++;
        end else begin
          exp_w = drive_expected.pop_front();
          if (out_motor_id !== exp_w.motor) begin
            $error("motor_id: expected %0d, got %0d", exp_w.motor, out_motor_id);
            fail_count++;
          end
          if (out_pin_level !== exp_w.pin) begin
            $error("pin_level: expected %0d, got %0d", exp_w.pin, out_pin_level);
            fail_count++;
          end
          if (out_pwm_duty !== exp_w.duty) begin
            $error("pwm_duty: expected %0d, got %0d", exp_w.duty, out_pwm_duty);
            fail_count++;
          end
          if (out_pulse_us !== exp_w.pulse) begin
            $error("pulse_us: expected %0d, got %0d", exp_w.pulse, out_pulse_us);
            fail_count++;
          end
        end
      end
      // long hold on request, random stall runs otherwise
      if (hold_seen != hold_asked) begin
        hold_seen = hold_asked;
        hold_left = LONG_HOLD;
      end else if (hold_left == 0) begin
        hold_left = pick_gap();
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------- test sequence

  initial begin
    logic [15:0] cf;
    // register defaults and neutral pulses after reset
    mode_r = MODE_SERVO; on_r = RST_ON_DUTY; coast_r = '0; off_r = '0;
    fs_r = RST_FULL_SCALE; gain_r = RST_GAIN; cf_r = '0; direct_r = 1'b0;
    pulse_mem[0] = PB'(NEUTRAL_US);
    pulse_mem[1] = PB'(NEUTRAL_US);
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // servo at reset settings: neutral, full throttle, unity translate gain
    send(mk_cmd(REQ_ON, 1'b0, 16'h0000, 1'b0, 16'h0000, 12'h000));
    send(mk_cmd(REQ_ON, 1'b1, 16'hFFFF, 1'b0, 16'h1234, 12'h000));
    send(mk_cmd(REQ_ON, 1'b0, 16'h0001, 1'b1, 16'hFFFF, 12'h000));
    send(mk_cmd(REQ_COAST, 1'b1, 16'hFFFF, 1'b1, 16'hFFFF, 12'hFFF));
    send(mk_cmd(REQ_OFF, 1'b0, 16'hFFFF, 1'b1, 16'hFFFF, 12'hFFF));
    send(mk_cmd(REQ_LOAD, 1'b1, 16'h0000, 1'b0, 16'h0000, 12'hFFF));
    send(mk_cmd(REQ_LOAD, 1'b0, 16'hFFFF, 1'b1, 16'hFFFF, 12'h000));
    wait_drained();

    // zero gain while translating, coast blend saturating both ways
    set_config(MODE_SERVO, 8'd255, 8'd0, 8'd0, 16'hFFFF, 16'h0000, 16'h7FFF, 1'b0);
    send(mk_cmd(REQ_ON, 1'b0, 16'hFFFF, 1'b1, 16'hFFFF, 12'h000));
    send(mk_cmd(REQ_LOAD, 1'b1, 16'h0000, 1'b0, 16'h0000, 12'hFFF));
    send(mk_cmd(REQ_COAST, 1'b1, 16'h0000, 1'b0, 16'hFFFF, 12'h000));
    send(mk_cmd(REQ_LOAD, 1'b0, 16'h0000, 1'b0, 16'h0000, 12'h000));
    send(mk_cmd(REQ_COAST, 1'b0, 16'h0000, 1'b0, 16'hFFFF, 12'h000));
    wait_drained();

    // direct control overrides translation, negative coast fraction is neutral
    set_config(MODE_SERVO, 8'd255, 8'd0, 8'd0, 16'hFFFF, 16'hFFFF, 16'h8000, 1'b1);
    send(mk_cmd(REQ_ON, 1'b1, 16'h8000, 1'b1, 16'hFFFF, 12'h000));
    send(mk_cmd(REQ_COAST, 1'b1, 16'h0000, 1'b1, 16'hFFFF, 12'h000));
    wait_drained();

    // dynamic pwm with zero full scale, then on below coast so the cap bites
    set_config(MODE_PWM_DYN, 8'd200, 8'd50, 8'd7, 16'h0000, 16'd16384, 16'h0000, 1'b0);
    send(mk_cmd(REQ_ON, 1'b0, 16'h0000, 1'b0, 16'h0000, 12'h000));
    send(mk_cmd(REQ_ON, 1'b1, 16'h0001, 1'b0, 16'h0000, 12'h000));
    send(mk_cmd(REQ_COAST, 1'b0, 16'hFFFF, 1'b0, 16'h0000, 12'h000));
    send(mk_cmd(REQ_OFF, 1'b1, 16'hFFFF, 1'b0, 16'h0000, 12'h000));
    send(mk_cmd(REQ_LOAD, 1'b0, 16'h0000, 1'b0, 16'h0000, 12'd1234));
    wait_drained();
    set_config(MODE_PWM_DYN, 8'd10, 8'd240, 8'd3, 16'hFFFF, 16'd16384, 16'h0000, 1'b0);
    send(mk_cmd(REQ_ON, 1'b0, 16'hFFFF, 1'b0, 16'h0000, 12'h000));
    send(mk_cmd(REQ_ON, 1'b1, 16'h0001, 1'b0, 16'h0000, 12'h000));
    wait_drained();

    // binary and fixed pwm leave stored pulses alone, load still writes them
    set_config(MODE_BINARY, 8'd255, 8'd0, 8'd0, 16'hFFFF, 16'd16384, 16'h0000, 1'b0);
    send(mk_cmd(REQ_ON, 1'b0, 16'h0000, 1'b0, 16'h0000, 12'h000));
    send(mk_cmd(REQ_COAST, 1'b1, 16'hFFFF, 1'b1, 16'hFFFF, 12'hFFF));
    send(mk_cmd(REQ_OFF, 1'b0, 16'hFFFF, 1'b1, 16'hFFFF, 12'hFFF));
    send(mk_cmd(REQ_LOAD, 1'b1, 16'h0000, 1'b0, 16'h0000, 12'd1800));
    wait_drained();
    set_config(MODE_PWM_FIXED, 8'd255, 8'd128, 8'd1, 16'hFFFF, 16'd16384, 16'h0000, 1'b0);
    send(mk_cmd(REQ_ON, 1'b1, 16'h0000, 1'b0, 16'h0000, 12'h000));
    send(mk_cmd(REQ_COAST, 1'b0, 16'h0000, 1'b0, 16'h0000, 12'h000));
    send(mk_cmd(REQ_OFF, 1'b1, 16'h0000, 1'b0, 16'h0000, 12'h000));
    wait_drained();

    // random phases, one register setting each
    for (int p = 0; p < 14; p++) begin
      if (p == 4) cf = 16'h7FFF;
      else if (p == 9) cf = 16'h8000;
      else cf = pick_word(16);
      set_config(mode_seq[p % 4], 8'(pick_word(8)), 8'(pick_word(8)), 8'(pick_word(8)),
                 pick_word(16), pick_word(16), cf, 1'($urandom_range(0, 1)));
      no_gaps = (p == 5);
      // receiver holds off while the sender keeps offering words
      if (p == 2 || p == 11) hold_asked++;
      for (int i = 0; i < 100; i++) begin
        // sender pauses mid phase until everything is back
        if (p == 7 && i == 50) wait_drained();
        send(rand_cmd());
      end
      wait_drained();
      no_gaps = 0;
    end

    wait_drained();
    repeat (60) @(posedge clk);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
